>>> hdl/slrl_pkg.sv
// ----------------------------------------------------------------------------
// slrl_pkg
// Shared widths, codes, control types and microcode for the sliding-log limiter.
// ----------------------------------------------------------------------------
package slrl_pkg;

	localparam int NOW_W     = 32;  // request time field
	localparam int COUNT_W   = 5;   // in_window_count field
	localparam int LIMIT_W   = 5;   // max_in_window register
	localparam int WINDOW_W  = 32;  // window_ticks register
	localparam int CFG_W     = 32;  // config write data
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 1'b1;

	localparam logic [LIMIT_W-1:0]  MAX_IN_WINDOW_RST = 5'd2;
	localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST  = 32'd1000;

	// program steps
	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_IDLE   = 2'd0;
	localparam logic [STEP_W-1:0] STEP_READ   = 2'd1;
	localparam logic [STEP_W-1:0] STEP_CHECK  = 2'd2;
	localparam logic [STEP_W-1:0] STEP_FINISH = 2'd3;

	// jump conditions
	localparam int COND_W = 2;
	localparam logic [COND_W-1:0] COND_NO_REQ   = 2'd0;
	localparam logic [COND_W-1:0] COND_EMPTY    = 2'd1;
	localparam logic [COND_W-1:0] COND_FRESH    = 2'd2;
	localparam logic [COND_W-1:0] COND_OUT_BUSY = 2'd3;

	// one microcode word: jump to target when cond holds, else go to next and
	// perform the fall-through ops (accept, pop, finish); read is unconditional
	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic [STEP_W-1:0] next;
		logic              op_accept;
		logic              op_read;
		logic              op_pop;
		logic              op_finish;
	} ucode_t;

	// sequencer -> datapath
	typedef struct packed {
		logic ready;   // input side open
		logic take;    // request accepted this cycle
		logic read;    // read oldest entry
		logic pop;     // drop oldest entry
		logic finish;  // decide, append, load result
	} act_t;

	// datapath -> sequencer
	typedef struct packed {
		logic no_req;
		logic empty;
		logic fresh;
		logic out_busy;
	} stat_t;

	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		case (step)
			STEP_IDLE: begin
				w.cond = COND_NO_REQ;   w.target = STEP_IDLE;   w.next = STEP_READ;
				w.op_accept = 1'b1;
			end
			STEP_READ: begin
				w.cond = COND_EMPTY;    w.target = STEP_FINISH; w.next = STEP_CHECK;
				w.op_read = 1'b1;
			end
			STEP_CHECK: begin
				w.cond = COND_FRESH;    w.target = STEP_FINISH; w.next = STEP_READ;
				w.op_pop = 1'b1;
			end
			STEP_FINISH: begin
				w.cond = COND_OUT_BUSY; w.target = STEP_FINISH; w.next = STEP_IDLE;
				w.op_finish = 1'b1;
			end
			default: begin
				w.cond = COND_NO_REQ;   w.target = STEP_IDLE;   w.next = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hdl/slrl_req_if.sv
// ----------------------------------------------------------------------------
// slrl_req_if
// Request channel: valid/ready handshake carrying the request time.
// ----------------------------------------------------------------------------
interface slrl_req_if
	import slrl_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [NOW_W-1:0] now_time;

	modport source (output valid, output now_time, input ready);
	modport sink   (input valid, input now_time, output ready);
endinterface

>>> hdl/slrl_res_if.sv
// ----------------------------------------------------------------------------
// slrl_res_if
// Result channel: valid/ready handshake carrying the allow decision and count.
// ----------------------------------------------------------------------------
interface slrl_res_if
	import slrl_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               allowed;
	logic [COUNT_W-1:0] in_window_count;

	modport source (output valid, output allowed, output in_window_count, input ready);
	modport sink   (input valid, input allowed, input in_window_count, output ready);
endinterface

>>> hdl/slrl_ram.sv
// ----------------------------------------------------------------------------
// slrl_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module slrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/slrl_seq.sv
// ----------------------------------------------------------------------------
// slrl_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module slrl_seq
	import slrl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output act_t  act
);

	logic [STEP_W-1:0] step_q;
	ucode_t            uw;
	logic              jump;

	assign uw = ucode(step_q);

	always_comb begin
		case (uw.cond)
			COND_NO_REQ:   jump = stat.no_req;
			COND_EMPTY:    jump = stat.empty;
			COND_FRESH:    jump = stat.fresh;
			COND_OUT_BUSY: jump = stat.out_busy;
			default:       jump = 1'b1;
		endcase
	end

	always_comb begin
		act.ready  = uw.op_accept;
		act.take   = uw.op_accept & ~jump;
		act.read   = uw.op_read;
		act.pop    = uw.op_pop & ~jump;
		act.finish = uw.op_finish & ~jump;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= jump ? uw.target : uw.next;
		end
	end

endmodule

>>> hdl/slrl_dp.sv
// ----------------------------------------------------------------------------
// slrl_dp
// Datapath: config registers, time ring, pointers, age compare, result register.
// ----------------------------------------------------------------------------
module slrl_dp
	import slrl_pkg::*;
#(
	parameter int RING_DEPTH = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  act_t                 act,
	output stat_t                stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic [NOW_W-1:0]     in_now_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_allowed,
	output logic [COUNT_W-1:0]   out_count
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

	logic [LIMIT_W-1:0]   max_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [TIME_BITS-1:0] now_q;
	logic [PTR_W-1:0]     oldest_q;
	logic [CNT_W-1:0]     count_q;
	logic                 res_valid_q;
	logic                 res_allowed_q;
	logic [COUNT_W-1:0]   res_count_q;

	logic [TIME_BITS-1:0] stamp;
	logic [TIME_BITS-1:0] age;
	logic [PTR_W-1:0]     oldest_inc;
	logic [SUM_W-1:0]     tail_sum;
	logic [PTR_W-1:0]     tail_ptr;
	logic [LIM_W-1:0]     limit;
	logic                 grant;
	logic [CNT_W-1:0]     count_new;

	slrl_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (act.finish & grant),
		.waddr (tail_ptr),
		.wdata (now_q),
		.re    (act.read),
		.raddr (oldest_q),
		.rdata (stamp)
	);

	// wrapping age of the oldest entry
	assign age = now_q - stamp;

	assign oldest_inc = (oldest_q == PTR_W'(RING_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);

	always_comb begin
		tail_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(RING_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(RING_DEPTH);
		end
		tail_ptr = tail_sum[PTR_W-1:0];
	end

	// limit saturates at ring depth
	assign limit = (LIM_W'(max_q) > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH) : LIM_W'(max_q);
	assign grant = LIM_W'(count_q) < limit;
	assign count_new = grant ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		stat.no_req   = ~in_valid;
		stat.empty    = (count_q == '0);
		stat.fresh    = CMP_W'(age) < CMP_W'(window_q);
		stat.out_busy = res_valid_q & ~out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_IN_WINDOW_RST;
			window_q <= WINDOW_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_IN_WINDOW: max_q    <= cfg_data[LIMIT_W-1:0];
				CFG_WINDOW_TICKS:  window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (act.pop) begin
				oldest_q <= oldest_inc;
				count_q  <= count_q - CNT_W'(1);
			end else if (act.finish) begin
				count_q <= count_new;
			end
			if (act.finish) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act.take) begin
			now_q <= TIME_BITS'(in_now_time);
		end
		if (act.finish) begin
			res_allowed_q <= grant;
			res_count_q   <= COUNT_W'(count_new);
		end
	end

	assign out_valid   = res_valid_q;
	assign out_allowed = res_allowed_q;
	assign out_count   = res_count_q;

endmodule

>>> hdl/sliding_log_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding_log_rate_limiter
// Sliding-window-log rate limiter driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Each request carries the current timer value. The block drops, oldest first,
// every logged time whose wrapping age is at least window_ticks, then allows
// the request and logs its time if fewer than min(max_in_window, RING_DEPTH)
// entries remain. One request is handled at a time: the request is accepted,
// then each logged entry examined gets a registered read from the time ring
// followed by the age compare, and then the decision is made. When the ring
// empties, the read finds it empty and goes straight to the decision. The
// decision waits while the previous result still sits unaccepted. The ring
// needs no clearing after reset. The result sits in an output register, so
// the next request is taken while the previous result waits; configuration
// is written only while the block is idle, a rule for the user that the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module sliding_log_rate_limiter
	import slrl_pkg::*;
#(
	parameter int RING_DEPTH = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	slrl_req_if.sink             req,
	slrl_res_if.source           res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	act_t  act;
	stat_t stat;

	slrl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.act    (act)
	);

	slrl_dp #(
		.RING_DEPTH (RING_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.act         (act),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (req.valid),
		.in_now_time (req.now_time),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.out_allowed (res.allowed),
		.out_count   (res.in_window_count)
	);

	assign req.ready = act.ready;

endmodule

>>> tb/sliding_log_rate_limiter_test.sv
// ----------------------------------------------------------------------------
// sliding_log_rate_limiter_test
// Self-checking bench: requests carrying timer values are sent under random
// idling on both channels, and every allow/deny result and count is compared
// with a local sliding-log predictor. Policy registers change between phases.
// ----------------------------------------------------------------------------
module sliding_log_rate_limiter_test
	import slrl_pkg::*;
	;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOG_DEPTH     = 16;
	localparam int SETTLE_CYCLES = 40;      // margin for the worst request, which examines every logged entry
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic               allowed;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	slrl_req_if req_ch ();
	slrl_res_if res_ch ();

	sliding_log_rate_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [NOW_W-1:0]    stamp_log [LOG_DEPTH];
	int unsigned         head;
	int unsigned         held;
	logic [LIMIT_W-1:0]  lim_reg;
	logic [WINDOW_W-1:0] win_reg;

	logic [NOW_W-1:0] req_times [$];
	verdict_t         verdicts [$];
	bit               calm;
	int               errors = 0;
	int               cycles = 0;

	always #4 clk = ~clk;

	function automatic verdict_t judge_request(input logic [NOW_W-1:0] now);
		verdict_t         v;
		logic [NOW_W-1:0] age;
		int unsigned      cap;
		while (held > 0) begin
			age = now - stamp_log[head];
			if (age < win_reg)
				break;
			head = (head + 1) % LOG_DEPTH;
			held--;
		end
		cap = (lim_reg > LOG_DEPTH) ? LOG_DEPTH : lim_reg;
		v.allowed = 1'b0;
		if (held < cap) begin
			stamp_log[(head + held) % LOG_DEPTH] = now;
			held++;
			v.allowed = 1'b1;
		end
		v.count = held[COUNT_W-1:0];
		return v;
	endfunction

	// sampled at the falling edge so that all rising-edge updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (req_times.size() != 0 || req_ch.valid || verdicts.size() != 0);
	endtask

	task automatic set_policy(input logic [LIMIT_W-1:0] lim, input logic [WINDOW_W-1:0] win);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_IN_WINDOW;
		cfg_data  <= CFG_W'(lim);
		@(posedge clk);
		cfg_index <= CFG_WINDOW_TICKS;
		cfg_data  <= CFG_W'(win);
		@(posedge clk);
		cfg_we  <= 1'b0;
		lim_reg = lim;
		win_reg = win;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.now_time <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				verdicts = {verdicts, judge_request(req_ch.now_time)};
			if (!req_ch.valid || req_ch.ready) begin
				if (req_times.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
					req_ch.valid    <= 1'b1;
					req_ch.now_time <= req_times[0];
					req_times.delete(0);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (verdicts.size() == 0) begin
					$display("%0t: unexpected result: allowed=%0b count=%0d", $time,
						res_ch.allowed, res_ch.in_window_count);
					errors++;
				end else begin
					want = verdicts[0];
					verdicts.delete(0);
					if (res_ch.allowed !== want.allowed) begin
						$display("%0t: allowed mismatch: expected %0b, actual %0b", $time,
							want.allowed, res_ch.allowed);
						errors++;
					end
					if (res_ch.in_window_count !== want.count) begin
						$display("%0t: in_window_count mismatch: expected %0d, actual %0d",
							$time, want.count, res_ch.in_window_count);
						errors++;
					end
				end
			end
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [NOW_W-1:0]    t;
		logic [LIMIT_W-1:0]  lim;
		logic [WINDOW_W-1:0] win;
		int unsigned         cap;
		int unsigned         span;
		int unsigned         pick;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_MAX_IN_WINDOW;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.now_time = '0;
		res_ch.ready    = 1'b0;
		lim_reg         = MAX_IN_WINDOW_RST;
		win_reg         = WINDOW_TICKS_RST;
		head            = 0;
		held            = 0;
		calm            = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset policy: fill, deny, expire on exact window age, timer wrap, time going back
		req_times = '{32'd0, 32'd1, 32'd2, 32'd1000, 32'hFFFF_FFFF, 32'd5, 32'd2};
		// zero limit still expires old entries
		set_policy(5'd0, WINDOW_TICKS_RST);
		req_times = {req_times, 32'd1500};
		// limit above depth, longest window: ring fills and the last one is denied
		set_policy(5'd31, 32'hFFFF_FFFF);
		repeat (17) req_times = {req_times, 32'h8000_0000};
		// zero window flushes the full ring
		set_policy(5'd31, 32'd0);
		req_times = {req_times, 32'h8000_0001};

		for (int ph = 0; ph < 10; ph++) begin
			pick = $urandom_range(0, 9);
			lim  = (pick == 0) ? 5'd0 : (pick == 1) ? LIMIT_W'($urandom_range(17, 31)) :
				(pick == 2) ? 5'd16 : LIMIT_W'($urandom_range(1, 15));
			pick = $urandom_range(0, 9);
			win  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : (pick == 2) ? $urandom :
				(pick == 3) ? 32'd1 : WINDOW_W'($urandom_range(2, 400));
			set_policy(lim, win);
			calm = (ph == 7);
			cap  = (lim > LOG_DEPTH) ? LOG_DEPTH : lim;
			// step size keeps the log hovering around the limit
			span = (win == 0 || win > 100000) ? 4 : 2 * win / (cap + 1) + 1;
			t    = $urandom;
			for (int n = 0; n < 42; n++) begin
				if (ph == 4 && n == 22)
					wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 6)
					t = t + $urandom;
				else if (pick < 10)
					t = t - $urandom_range(1, span);
				else
					t = t + $urandom_range(0, span);
				req_times = {req_times, t};
			end
		end

		wait_drained();
		calm = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/slrl_pkg.sv
hdl/slrl_req_if.sv
hdl/slrl_res_if.sv
hdl/slrl_ram.sv
hdl/slrl_seq.sv
hdl/slrl_dp.sv
hdl/sliding_log_rate_limiter.sv
tb/sliding_log_rate_limiter_test.sv
